### hw/rtl/pplc_pkg.sv
// pplc_pkg: shared constants, codes and types of the pinned priority lru byte cache
// used by pplc_ram users, pplc_ctrl, pplc_dpath and the top level
`default_nettype none

package pplc_pkg;

	localparam int SLOTS    = 64;
	localparam int PIN_BITS = 8;
	localparam int PIN_KINDS = 4;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);

	localparam logic [2:0] FN_INSERT  = 3'd0;
	localparam logic [2:0] FN_LOOKUP  = 3'd1;
	localparam logic [2:0] FN_SETPRIO = 3'd2;
	localparam logic [2:0] FN_PIN     = 3'd3;
	localparam logic [2:0] FN_UNPIN   = 3'd4;
	localparam logic [2:0] FN_RELEASE = 3'd5;
	localparam logic [2:0] FN_CLEAR   = 3'd6;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISS    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_EVICTED = 2'd3;

	localparam logic [1:0] PRIO_RSVD  = 2'd3;
	localparam logic [1:0] PRIO_BG    = 2'd0;

	typedef struct packed {
		logic [PIN_KINDS*PIN_BITS-1:0] pins;
		logic                          pend;
		logic [47:0]                   last_use;
		logic [1:0]                    prio;
		logic [39:0]                   cost;
		logic [31:0]                   handle;
	} entry_t;

	typedef struct packed {
		logic              latch;
		logic              cand_load;
		logic              retry;
		logic              scan_init;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              ev_find;
		logic              ev_victim;
		logic [SLOT_W-1:0] ev_idx;
		logic              ins_write;
		logic              mod_write;
		logic              remove_match;
		logic              evict;
		logic              clear_all;
		logic              load_out;
		logic [1:0]        out_code;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       id_zero;
		logic       cost_ok;
		logic       found;
		logic       free_found;
		logic       over;
		logic       victim_found;
		logic       unpin_remove;
		logic       pins_nz;
		logic       new_valid;
	} dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/pinned_priority_lru_byte_cache.sv
// pinned_priority_lru_byte_cache: byte budgeted handle table, top level
// sequence: accept, dispatch, a scan over all slots, find decision, a trim check if needed, result
// each insert handle retry adds another scan, each evicted entry a victim scan and trim check (one ram read port)
// one request at a time: in_stall stays high until the result is loaded into the output registers
// reset: arst_n clears the table, byte count and use clock, sets the handle counter to 1 and the budget to 268435456
// depends on pplc_pkg, pplc_ctrl, pplc_dpath, pplc_ram
`default_nettype none

module pinned_priority_lru_byte_cache
	import pplc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// budget register
	input  wire logic        cfg_we,
	input  wire logic [39:0] cfg_wdata,
	// request channel
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [2:0]  func,
	input  wire logic [31:0] entry_id,
	input  wire logic [39:0] byte_cost,
	input  wire logic [1:0]  priority_req,
	input  wire logic [1:0]  pin_kind,
	// result channel
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [1:0]  status,
	output      logic [31:0] assigned_id,
	output      logic [1:0]  found_priority,
	output      logic [39:0] found_cost,
	output      logic [39:0] total_bytes,
	output      logic [6:0]  entry_count,
	output      logic [6:0]  evicted_count
);

	// command and status between sequencer and table datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: request accept, scans, trim loop, result handoff
	pplc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: slot ram, valid bits, counters, compares, result registers
	pplc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.func           (func),
		.entry_id       (entry_id),
		.byte_cost      (byte_cost),
		.priority_req   (priority_req),
		.pin_kind       (pin_kind),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.assigned_id    (assigned_id),
		.found_priority (found_priority),
		.found_cost     (found_cost),
		.total_bytes    (total_bytes),
		.entry_count    (entry_count),
		.evicted_count  (evicted_count)
	);

endmodule

`default_nettype wire

### hw/rtl/pplc_ram.sv
// pplc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pplc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pplc_dpath.sv
// pplc_dpath: slot table, byte and use counters, scan compares and result registers
// depends on pplc_pkg and pplc_ram
`default_nettype none

module pplc_dpath
	import pplc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [39:0]   cfg_wdata,
	input  wire logic [2:0]    func,
	input  wire logic [31:0]   entry_id,
	input  wire logic [39:0]   byte_cost,
	input  wire logic [1:0]    priority_req,
	input  wire logic [1:0]    pin_kind,
	input  wire dp_cmd_t       cmd,
	output      dp_sts_t       sts,
	output      logic [1:0]    status,
	output      logic [31:0]   assigned_id,
	output      logic [1:0]    found_priority,
	output      logic [39:0]   found_cost,
	output      logic [39:0]   total_bytes,
	output      logic [6:0]    entry_count,
	output      logic [6:0]    evicted_count
);

	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	logic [39:0]       budget_q, held_q;
	logic [47:0]       clock_q;
	logic [31:0]       next_q, cand_q;
	logic [CNT_W-1:0]  count_q, evicted_q;
	logic [SLOTS-1:0]  valid_q;

	logic [2:0]        op_func_q;
	logic [31:0]       op_id_q;
	logic [39:0]       op_cost_q;
	logic [1:0]        op_prio_q;
	logic [1:0]        op_kind_q;

	logic              found_q, free_found_q, v_found_q;
	logic [SLOT_W-1:0] m_idx_q, free_idx_q, v_idx_q;
	entry_t            m_ent_q;
	logic [1:0]        v_prio_q;
	logic [47:0]       v_lu_q;
	logic [39:0]       v_cost_q;

	entry_t            rd_ent, ins_ent, mod_ent, wr_ent;
	logic [$bits(entry_t)-1:0] rdata;
	logic              ram_we;
	logic [SLOT_W-1:0] waddr;
	logic [47:0]       stamp_val;
	logic [31:0]       key;
	logic [PIN_BITS-1:0] pin_cnt;
	logic [40:0]       add_sum;
	logic [39:0]       sub_val;
	logic              ev_valid, better;

	function automatic logic [31:0] inc_handle(input logic [31:0] h);
		logic [31:0] n;
		n = h + 32'd1;
		return (n == 32'd0) ? 32'd1 : n;
	endfunction

	pplc_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wr_ent),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr),
		.rdata (rdata)
	);

	assign rd_ent    = entry_t'(rdata);
	assign stamp_val = clock_q + 48'd1;
	assign key       = (op_func_q == FN_INSERT) ? cand_q : op_id_q;
	assign pin_cnt   = m_ent_q.pins[op_kind_q*PIN_BITS +: PIN_BITS];
	assign ev_valid  = valid_q[cmd.ev_idx];
	assign better    = !v_found_q || (rd_ent.prio < v_prio_q) ||
		((rd_ent.prio == v_prio_q) && (rd_ent.last_use < v_lu_q));
	assign add_sum   = {1'b0, held_q} + {1'b0, op_cost_q};
	assign sub_val   = cmd.remove_match ? m_ent_q.cost : v_cost_q;

	always_comb begin
		ins_ent          = '0;
		ins_ent.handle   = cand_q;
		ins_ent.cost     = op_cost_q;
		ins_ent.prio     = op_prio_q;
		ins_ent.last_use = stamp_val;
		mod_ent          = m_ent_q;
		mod_ent.last_use = stamp_val;
		case (op_func_q)
			FN_SETPRIO: mod_ent.prio = op_prio_q;
			FN_PIN: begin
				if (pin_cnt != PIN_MAX) begin
					mod_ent.pins[op_kind_q*PIN_BITS +: PIN_BITS] = pin_cnt + 1'b1;
				end
			end
			FN_UNPIN: begin
				if (pin_cnt != '0) begin
					mod_ent.pins[op_kind_q*PIN_BITS +: PIN_BITS] = pin_cnt - 1'b1;
				end
			end
			FN_RELEASE: mod_ent.pend = 1'b1;
			default: ;
		endcase
		ram_we = cmd.ins_write || cmd.mod_write;
		waddr  = cmd.ins_write ? free_idx_q : m_idx_q;
		wr_ent = cmd.ins_write ? ins_ent : mod_ent;
	end

	always_comb begin
		sts              = '0;
		sts.func         = op_func_q;
		sts.id_zero      = (op_id_q == 32'd0);
		sts.cost_ok      = (op_cost_q != 40'd0) && (op_cost_q <= budget_q);
		sts.found        = found_q;
		sts.free_found   = free_found_q;
		sts.over         = held_q > budget_q;
		sts.victim_found = v_found_q;
		sts.unpin_remove = m_ent_q.pend && (mod_ent.pins == '0);
		sts.pins_nz      = m_ent_q.pins != '0;
		sts.new_valid    = valid_q[free_idx_q];
	end

	// control-state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q  <= 40'd268435456;
			held_q    <= '0;
			clock_q   <= '0;
			next_q    <= 32'd1;
			count_q   <= '0;
			valid_q   <= '0;
			evicted_q <= '0;
		end else begin
			if (cfg_we) begin
				budget_q <= cfg_wdata;
			end
			if (cmd.latch) begin
				evicted_q <= '0;
			end
			if (cmd.retry || cmd.ins_write) begin
				next_q <= inc_handle(next_q);
			end
			if (cmd.ins_write || cmd.mod_write) begin
				clock_q <= stamp_val;
			end
			if (cmd.ins_write) begin
				valid_q[free_idx_q] <= 1'b1;
				count_q <= count_q + 1'b1;
				held_q  <= add_sum[40] ? '1 : add_sum[39:0];
			end
			if (cmd.remove_match || cmd.evict) begin
				valid_q[cmd.remove_match ? m_idx_q : v_idx_q] <= 1'b0;
				count_q <= count_q - 1'b1;
				held_q  <= (held_q >= sub_val) ? held_q - sub_val : '0;
			end
			if (cmd.evict) begin
				evicted_q <= evicted_q + 1'b1;
			end
			if (cmd.clear_all) begin
				valid_q <= '0;
				held_q  <= '0;
				count_q <= '0;
			end
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_func_q <= func;
			op_id_q   <= entry_id;
			op_cost_q <= byte_cost;
			op_prio_q <= (priority_req == PRIO_RSVD) ? PRIO_BG : priority_req;
			op_kind_q <= pin_kind;
		end
		if (cmd.cand_load) begin
			cand_q <= next_q;
		end
		if (cmd.retry) begin
			cand_q <= inc_handle(next_q);
		end
		if (cmd.scan_init) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			v_found_q    <= 1'b0;
		end
		if (cmd.ev_find) begin
			if (ev_valid && !found_q && (rd_ent.handle == key)) begin
				found_q <= 1'b1;
				m_idx_q <= cmd.ev_idx;
				m_ent_q <= rd_ent;
			end
			if (!ev_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= cmd.ev_idx;
			end
		end
		if (cmd.ev_victim && ev_valid && (rd_ent.pins == '0) && better) begin
			v_found_q <= 1'b1;
			v_idx_q   <= cmd.ev_idx;
			v_prio_q  <= rd_ent.prio;
			v_lu_q    <= rd_ent.last_use;
			v_cost_q  <= rd_ent.cost;
		end
		if (cmd.load_out) begin
			status         <= cmd.out_code;
			assigned_id    <= (op_func_q == FN_INSERT && cmd.out_code == ST_OK) ? cand_q : '0;
			found_priority <= (op_func_q == FN_LOOKUP && cmd.out_code == ST_OK) ?
				m_ent_q.prio : '0;
			found_cost     <= (op_func_q == FN_LOOKUP && cmd.out_code == ST_OK) ?
				m_ent_q.cost : '0;
			total_bytes    <= held_q;
			entry_count    <= 7'(count_q);
			evicted_count  <= 7'(evicted_q);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pplc_ctrl.sv
// pplc_ctrl: sequencer for table scans, updates, trim loop and result handoff
// depends on pplc_pkg
`default_nettype none

module pplc_ctrl
	import pplc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output      logic    in_stall,
	output      logic    out_valid,
	input  wire logic    out_stall,
	input  wire dp_sts_t sts,
	output      dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_SCAN, S_DEC_FIND, S_TRIM_CHK, S_DEC_VIC, S_OUT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ev_s1, kind_q, out_valid_q;
	logic [SLOT_W-1:0] ev_idx_s1;
	logic [1:0]        code_q, trim_code;
	logic              scan_op;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign trim_code = (sts.func == FN_INSERT) ? (sts.new_valid ? ST_OK : ST_EVICTED) : ST_OK;
	assign scan_op   = (sts.func inside {FN_LOOKUP, FN_SETPRIO, FN_PIN, FN_UNPIN,
		FN_RELEASE}) && !sts.id_zero;

	always_comb begin
		cmd           = '0;
		cmd.rd_addr   = cnt_q[SLOT_W-1:0];
		cmd.ev_idx    = ev_idx_s1;
		cmd.ev_find   = ev_s1 && !kind_q;
		cmd.ev_victim = ev_s1 && kind_q;
		cmd.out_code  = code_q;
		case (state_q)
			S_IDLE: cmd.latch = in_valid;
			S_DISPATCH: begin
				if (sts.func == FN_CLEAR) begin
					cmd.clear_all = 1'b1;
				end else if (sts.func == FN_INSERT && sts.cost_ok) begin
					cmd.cand_load = 1'b1;
					cmd.scan_init = 1'b1;
				end else if (scan_op) begin
					cmd.scan_init = 1'b1;
				end
			end
			S_SCAN: cmd.rd_en = (cnt_q < CNT_W'(SLOTS));
			S_DEC_FIND: begin
				if (sts.func == FN_INSERT) begin
					if (sts.free_found && sts.found) begin
						cmd.retry     = 1'b1;
						cmd.scan_init = 1'b1;
					end else if (sts.free_found) begin
						cmd.ins_write = 1'b1;
					end
				end else if (sts.found) begin
					case (sts.func)
						FN_RELEASE: begin
							cmd.mod_write    = sts.pins_nz;
							cmd.remove_match = !sts.pins_nz;
						end
						FN_UNPIN: begin
							cmd.mod_write    = 1'b1;
							cmd.remove_match = sts.unpin_remove;
						end
						default: cmd.mod_write = 1'b1;
					endcase
				end
			end
			S_TRIM_CHK: cmd.scan_init = sts.over;
			S_DEC_VIC: cmd.evict = sts.victim_found;
			S_OUT: cmd.load_out = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ev_s1       <= 1'b0;
			ev_idx_s1   <= '0;
			kind_q      <= 1'b0;
			code_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			ev_s1 <= (state_q == S_SCAN) && (cnt_q < CNT_W'(SLOTS));
			if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					cnt_q  <= '0;
					kind_q <= 1'b0;
					if (sts.func == FN_CLEAR) begin
						code_q  <= ST_OK;
						state_q <= S_OUT;
					end else if ((sts.func == FN_INSERT && sts.cost_ok) || scan_op) begin
						state_q <= S_SCAN;
					end else begin
						code_q  <= ST_MISS;
						state_q <= S_OUT;
					end
				end
				S_SCAN: begin
					ev_idx_s1 <= cnt_q[SLOT_W-1:0];
					if (cnt_q < CNT_W'(SLOTS)) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= kind_q ? S_DEC_VIC : S_DEC_FIND;
					end
				end
				S_DEC_FIND: begin
					cnt_q <= '0;
					if (sts.func == FN_INSERT) begin
						if (!sts.free_found) begin
							code_q  <= ST_FULL;
							state_q <= S_OUT;
						end else if (sts.found) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_TRIM_CHK;
						end
					end else if (!sts.found) begin
						code_q  <= ST_MISS;
						state_q <= S_OUT;
					end else if (sts.func == FN_SETPRIO ||
						(sts.func == FN_UNPIN && !sts.unpin_remove)) begin
						state_q <= S_TRIM_CHK;
					end else begin
						code_q  <= ST_OK;
						state_q <= S_OUT;
					end
				end
				S_TRIM_CHK: begin
					cnt_q  <= '0;
					kind_q <= 1'b1;
					if (sts.over) begin
						state_q <= S_SCAN;
					end else begin
						code_q  <= trim_code;
						state_q <= S_OUT;
					end
				end
				S_DEC_VIC: begin
					if (sts.victim_found) begin
						state_q <= S_TRIM_CHK;
					end else begin
						code_q  <= trim_code;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_evict_needs_victim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> sts.victim_found && sts.over)
		else $error("eviction without a victim or without overrun");

	a_insert_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_write |-> sts.free_found && !sts.found)
		else $error("insert without a free slot or with a handle in use");

	a_single_removal: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.evict && cmd.remove_match))
		else $error("two removals in one cycle");

	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid && state_q == S_IDLE)
		else $error("result load did not raise out_valid");

endmodule

`default_nettype wire

### test/tb.sv
// tb: self-checking testbench of the pinned priority lru byte cache
// depends on pplc_pkg and the pinned_priority_lru_byte_cache top level
`default_nettype none

module tb;
	import pplc_pkg::*;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	// block inputs, all known from time zero
	logic        cfg_we = 1'b0;
	logic [39:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic [2:0]  func = '0;
	logic [31:0] entry_id = '0;
	logic [39:0] byte_cost = '0;
	logic [1:0]  priority_req = '0;
	logic [1:0]  pin_kind = '0;
	logic        out_stall = 1'b0;

	// block outputs
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  status;
	logic [31:0] assigned_id;
	logic [1:0]  found_priority;
	logic [39:0] found_cost;
	logic [39:0] total_bytes;
	logic [6:0]  entry_count;
	logic [6:0]  evicted_count;

	pinned_priority_lru_byte_cache i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .entry_id(entry_id), .byte_cost(byte_cost),
		.priority_req(priority_req), .pin_kind(pin_kind),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .assigned_id(assigned_id),
		.found_priority(found_priority), .found_cost(found_cost),
		.total_bytes(total_bytes), .entry_count(entry_count),
		.evicted_count(evicted_count)
	);

	localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
	localparam logic [2:0]  FN_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] assigned;
		logic [1:0]  fprio;
		logic [39:0] fcost;
		logic [39:0] total;
		logic [6:0]  count;
		logic [6:0]  evicted;
	} cache_result_t;

	// shadow copy of the cache table
	logic        sh_valid [SLOTS];
	logic [31:0] sh_handle [SLOTS];
	logic [39:0] sh_cost [SLOTS];
	logic [1:0]  sh_prio [SLOTS];
	logic [47:0] sh_use [SLOTS];
	logic        sh_pend [SLOTS];
	logic [7:0]  sh_pins [SLOTS][PIN_KINDS];
	logic [39:0] sh_held;
	logic [47:0] sh_clock;
	logic [31:0] sh_next;
	logic [39:0] sh_budget;

	cache_result_t pending_results[$];
	int  fail_count = 0;
	int  result_count = 0;
	int  request_count = 0;
	int  send_idle_pct = 0;
	int  stall_pct = 0;

	// handles the cache has given out, used to aim requests at live entries
	logic [31:0] known_handles[$];

	function automatic int slot_of(input logic [31:0] h);
		for (int i = 0; i < SLOTS; i++)
			if (sh_valid[i] && sh_handle[i] == h)
				return i;
		return -1;
	endfunction

	function automatic logic [47:0] next_stamp();
		sh_clock = sh_clock + 48'd1;
		return sh_clock;
	endfunction

	function automatic bit is_pinned(input int s);
		for (int k = 0; k < PIN_KINDS; k++)
			if (sh_pins[s][k] != 0)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void drop_slot(input int s);
		sh_held = (sh_held >= sh_cost[s]) ? sh_held - sh_cost[s] : '0;
		sh_valid[s] = 1'b0;
	endfunction

	// evict unpinned entries, lowest priority then oldest, until within budget or none is left
	function automatic logic [6:0] trim_to_budget();
		logic [6:0] n;
		int v;
		n = '0;
		while (sh_held > sh_budget) begin
			v = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (!sh_valid[i] || is_pinned(i))
					continue;
				if (v < 0 || sh_prio[i] < sh_prio[v] ||
				    (sh_prio[i] == sh_prio[v] && sh_use[i] < sh_use[v]))
					v = i;
			end
			if (v < 0)
				break;
			drop_slot(v);
			n++;
		end
		return n;
	endfunction

	function automatic void reset_shadow();
		for (int i = 0; i < SLOTS; i++)
			sh_valid[i] = 1'b0;
		sh_held = '0;
		sh_clock = '0;
		sh_next = 32'd1;
		sh_budget = 40'd268435456;
	endfunction

	function automatic cache_result_t predict_cache(input logic [2:0] fn,
			input logic [31:0] id, input logic [39:0] cost,
			input logic [1:0] prio_in, input logic [1:0] kind);
		cache_result_t r;
		logic [1:0] prio;
		logic [31:0] h;
		int fs, s;
		logic [6:0] cnt;
		r = '0;
		r.status = ST_MISS;
		prio = (prio_in == PRIO_RSVD) ? PRIO_BG : prio_in;
		if (fn == FN_INSERT) begin
			if (cost != 0 && cost <= sh_budget) begin
				fs = -1;
				for (int i = 0; i < SLOTS && fs < 0; i++)
					if (!sh_valid[i])
						fs = i;
				if (fs < 0)
					r.status = ST_FULL;
				else begin
					h = '0;
					for (int t = 0; t <= SLOTS; t++) begin
						h = sh_next;
						sh_next = sh_next + 32'd1;
						if (sh_next == 0)
							sh_next = 32'd1;
						if (slot_of(h) < 0)
							break;
					end
					sh_valid[fs] = 1'b1;
					sh_handle[fs] = h;
					sh_cost[fs] = cost;
					sh_prio[fs] = prio;
					sh_use[fs] = next_stamp();
					sh_pend[fs] = 1'b0;
					for (int k = 0; k < PIN_KINDS; k++)
						sh_pins[fs][k] = '0;
					sh_held = ({1'b0, sh_held} + {1'b0, cost} > {1'b0, MAX40}) ?
						MAX40 : sh_held + cost;
					r.evicted = trim_to_budget();
					if (slot_of(h) >= 0) begin
						r.status = ST_OK;
						r.assigned = h;
						known_handles = {known_handles, h};
					end else
						r.status = ST_EVICTED;
				end
			end
		end else if (fn == FN_CLEAR) begin
			for (int i = 0; i < SLOTS; i++)
				sh_valid[i] = 1'b0;
			sh_held = '0;
			r.status = ST_OK;
		end else if (fn != FN_UNUSED && id != 0 && slot_of(id) >= 0) begin
			s = slot_of(id);
			r.status = ST_OK;
			case (fn)
				FN_LOOKUP: begin
					sh_use[s] = next_stamp();
					r.fprio = sh_prio[s];
					r.fcost = sh_cost[s];
				end
				FN_SETPRIO: begin
					sh_prio[s] = prio;
					sh_use[s] = next_stamp();
					r.evicted = trim_to_budget();
				end
				FN_PIN: begin
					if (sh_pins[s][kind] != 8'hFF)
						sh_pins[s][kind]++;
					sh_use[s] = next_stamp();
				end
				FN_UNPIN: begin
					if (sh_pins[s][kind] != 0)
						sh_pins[s][kind]--;
					sh_use[s] = next_stamp();
					// a pending release completes at the last unpin
					if (sh_pend[s] && !is_pinned(s))
						drop_slot(s);
					else
						r.evicted = trim_to_budget();
				end
				default: begin
					if (is_pinned(s)) begin
						sh_pend[s] = 1'b1;
						sh_use[s] = next_stamp();
					end else
						drop_slot(s);
				end
			endcase
		end
		cnt = '0;
		for (int i = 0; i < SLOTS; i++)
			if (sh_valid[i])
				cnt++;
		r.total = sh_held;
		r.count = cnt;
		return r;
	endfunction

	// send one request, predicting its result at acceptance
	task automatic send_request(input logic [2:0] fn, input logic [31:0] id,
			input logic [39:0] cost, input logic [1:0] prio, input logic [1:0] kind);
		cache_result_t exp_r;
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct)
			@(negedge clk);
		func <= fn;
		entry_id <= id;
		byte_cost <= cost;
		priority_req <= prio;
		pin_kind <= kind;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		exp_r = predict_cache(fn, id, cost, prio, kind);
		pending_results = {pending_results, exp_r};
		request_count++;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// budget writes only with the block idle
	task automatic write_budget(input logic [39:0] b);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SLOTS * 70)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= b;
		@(negedge clk);
		cfg_we <= 1'b0;
		sh_budget = b;
	endtask

	function automatic logic [31:0] pick_handle();
		int r;
		r = $urandom_range(99, 0);
		if (r < 80 && known_handles.size() != 0)
			return known_handles[$urandom_range(known_handles.size() - 1, 0)];
		if (r < 88)
			return '0;
		return $urandom();
	endfunction

	// result checker
	always @(posedge clk) begin
		cache_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, assigned_id, found_priority, found_cost,
				total_bytes, entry_count, evicted_count};
			result_count++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.assigned != want.assigned)
					$display("%0t: assigned_id exp %0h got %0h", $time,
						want.assigned, got.assigned);
				if (got.fprio != want.fprio)
					$display("%0t: found_priority exp %0d got %0d", $time,
						want.fprio, got.fprio);
				if (got.fcost != want.fcost)
					$display("%0t: found_cost exp %0h got %0h", $time,
						want.fcost, got.fcost);
				if (got.total != want.total)
					$display("%0t: total_bytes exp %0h got %0h", $time,
						want.total, got.total);
				if (got.count != want.count)
					$display("%0t: entry_count exp %0d got %0d", $time,
						want.count, got.count);
				if (got.evicted != want.evicted)
					$display("%0t: evicted_count exp %0d got %0d", $time,
						want.evicted, got.evicted);
				if (got != want)
					fail_count++;
			end
		end
	end

	// receiver stall, redrawn every falling edge
	always @(negedge clk)
		out_stall <= ($urandom_range(99, 0) < stall_pct);

	// directed requests: each op, extremes and the named corner cases
	task automatic test_directed();
		logic [31:0] h;
		send_request(FN_INSERT, '0, '0, 2'd0, 2'd0);              // zero cost
		send_request(FN_INSERT, '0, MAX40, 2'd0, 2'd0);           // over budget
		send_request(FN_INSERT, 32'hFFFF_FFFF, 40'd100, PRIO_RSVD, 2'd3);
		h = known_handles[$];
		send_request(FN_LOOKUP, h, '0, 2'd0, 2'd0);
		send_request(FN_LOOKUP, '0, '0, 2'd0, 2'd0);               // empty handle
		send_request(FN_LOOKUP, 32'hDEAD_BEEF, '0, 2'd0, 2'd0);    // unknown handle
		send_request(FN_SETPRIO, h, '0, 2'd2, 2'd0);
		send_request(FN_PIN, h, '0, 2'd0, 2'd3);
		send_request(FN_RELEASE, h, '0, 2'd0, 2'd0);               // deferred release
		send_request(FN_UNPIN, h, '0, 2'd0, 2'd0);                 // unpin at zero
		send_request(FN_UNPIN, h, '0, 2'd0, 2'd3);                 // removed at last unpin
		send_request(FN_UNUSED, 32'd1, MAX40, 2'd3, 2'd3);
		send_request(FN_INSERT, '0, 40'd268435456, 2'd1, 2'd1);
		send_request(FN_INSERT, '0, 40'd200, 2'd2, 2'd0);          // evicts older entry
		send_request(FN_INSERT, '0, 40'd268435456, 2'd0, 2'd0);    // new entry evicted
		send_request(FN_CLEAR, '0, '0, 2'd0, 2'd0);
	endtask

	// pin saturation at 255
	task automatic test_pin_saturation();
		logic [31:0] h;
		send_request(FN_INSERT, '0, 40'd1, 2'd2, 2'd0);
		h = known_handles[$];
		repeat (258)
			send_request(FN_PIN, h, '0, 2'd0, 2'd2);
		repeat (2)
			send_request(FN_UNPIN, h, '0, 2'd0, 2'd2);
		send_request(FN_CLEAR, '0, '0, 2'd0, 2'd0);
	endtask

	// fill past the table size for the full case
	task automatic test_full_table();
		repeat (SLOTS + 2)
			send_request(FN_INSERT, '0, 40'($urandom_range(1000, 1)),
				2'($urandom_range(3, 0)), 2'd0);
		send_request(FN_CLEAR, '0, '0, 2'd0, 2'd0);
	endtask

	// saturating byte count under the largest budget
	task automatic test_byte_saturation();
		write_budget(MAX40);
		send_request(FN_INSERT, '0, MAX40, 2'd1, 2'd0);
		send_request(FN_PIN, known_handles[$], '0, 2'd0, 2'd1);
		send_request(FN_INSERT, '0, MAX40 - 40'd5, 2'd0, 2'd0);
		send_request(FN_SETPRIO, known_handles[$], '0, 2'd0, 2'd0);
		write_budget(40'd0);
		send_request(FN_INSERT, '0, 40'd1, 2'd0, 2'd0);            // zero budget rejects
		send_request(FN_UNPIN, known_handles[$ - 1], '0, 2'd0, 2'd1);
		send_request(FN_CLEAR, '0, '0, 2'd0, 2'd0);
	endtask

	// random mix over several budgets and idling phases
	task automatic test_random(input int n, input logic [39:0] budget,
			input int idle, input int stall);
		int r;
		logic [39:0] cost;
		write_budget(budget);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99, 0);
			if (r < 5)
				cost = $urandom_range(3, 0) == 0 ? 40'({$urandom(), $urandom()}) : '0;
			else
				cost = (budget < 40'd64) ? 40'($urandom_range(70, 1)) :
					40'($urandom_range(1000, 1)) * (budget / 40'd4000 + 40'd1);
			if (r < 35)
				send_request(FN_INSERT, $urandom(), cost, 2'($urandom_range(3, 0)),
					2'($urandom_range(3, 0)));
			else if (r < 98)
				send_request(3'($urandom_range(5, 1)), pick_handle(),
					40'({$urandom(), $urandom()}),
					2'($urandom_range(3, 0)), 2'($urandom_range(3, 0)));
			else
				send_request($urandom_range(99, 0) < 50 ? FN_CLEAR : FN_UNUSED,
					$urandom(), 40'({$urandom(), $urandom()}), 2'($urandom_range(3, 0)),
					2'($urandom_range(3, 0)));
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		reset_shadow();
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_pin_saturation();
		test_full_table();
		test_byte_saturation();
		test_random(250, 40'd100000, 0, 0);
		test_random(200, 40'd50, 87, 0);
		test_random(200, 40'd1, 0, 87);
		test_random(250, 40'd20000000, 12, 12);
		test_random(150, 40'd268435456, 0, 0);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SLOTS * 70)
			@(negedge clk);
		$display("covered %0d requests and %0d results: all ops, pins, deferred release,",
			request_count, result_count);
		$display("full table, rejects, saturation and five budgets under idle and stall");
		if (fail_count == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit
	initial begin
		#80000000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hw/rtl/pplc_pkg.sv
hw/rtl/pplc_ram.sv
hw/rtl/pplc_dpath.sv
hw/rtl/pplc_ctrl.sv
hw/rtl/pinned_priority_lru_byte_cache.sv
test/tb.sv
